### sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge while reset is low.
`define PACR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define PACR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/pacr_pkg.sv
package pacr_pkg;

  // Cache geometry.
  localparam int NUM_SETS  = 2048;
  localparam int SET_W     = 11;
  localparam int NUM_WAYS  = 16;
  localparam int WAY_W     = 4;
  localparam int ADDR_W    = 48;
  localparam int LINE_SHIFT = 6;
  localparam int LA_W      = ADDR_W - LINE_SHIFT;

  // Spatial window: four line addresses per memory row.
  localparam int WINDOW    = 64;
  localparam int PTR_W     = 6;
  localparam int ROW_ENTS  = 4;
  localparam int ROW_SEL_W = 2;
  localparam int ROWS      = WINDOW / ROW_ENTS;
  localparam int ROW_AW    = 4;
  localparam int WIN_ROW_W = ROW_ENTS * LA_W;

  // One counter walks window rows and ways together (both sixteen).
  localparam int SCAN_W    = 4;
  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(NUM_WAYS - 1);

  localparam int FREQ_W    = 4;
  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
  localparam int TALLY_W   = 16;
  localparam int CNT_W     = 7;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR  = 1'b1;
  localparam logic [CNT_W-1:0] THRESHOLD_RST = 7'd18;
  localparam logic [CFG_DATA_W-1:0] NEIGHBOR_RST = 8'd2;

  // Policy modes.
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_LFU     = 2'd0;
  localparam mode_t MODE_NRU     = 2'd1;
  localparam mode_t MODE_SPATIAL = 2'd2;

  // Commands.
  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef struct packed {
    logic [LA_W-1:0]   tag;
    logic [FREQ_W-1:0] freq;
    logic              stale;
  } way_entry_t;

  typedef way_entry_t [NUM_WAYS-1:0] way_row_t;

  typedef struct packed {
    logic                wrapped;
    logic [PTR_W-1:0]    ptr;
    logic [CNT_W-1:0]    scount;
    logic [TALLY_W-1:0]  hits;
    logic [TALLY_W-1:0]  misses;
    mode_t               mode;
  } set_state_t;

  function automatic logic [LA_W-1:0] la_dist(input logic [LA_W-1:0] a,
                                              input logic [LA_W-1:0] b);
    la_dist = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic la_near(input logic [LA_W-1:0] a,
                                   input logic [LA_W-1:0] b,
                                   input logic [CFG_DATA_W-1:0] nd);
    la_near = la_dist(a, b) <= LA_W'(nd);
  endfunction

endpackage

### sv/phase_adaptive_cache_replacement_core.sv
// A victim query reads the set state and way row, scans, commits the window entry
// and phase, then offers its output beat; an update writes back and gives no beat.
// The scan walks the 16-row window memory (four line addresses a row) and the
// 16 ways together, one a cycle; input stalls until the current item is done.
// Reset: synchronous; afterwards a clearing pass writes the state and way row of
// all 2048 sets while input is stalled; configuration writes are taken throughout.
module phase_adaptive_cache_replacement_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               command,
  input  logic [pacr_pkg::SET_W-1:0]         set_index,
  input  logic [pacr_pkg::ADDR_W-1:0]        phys_addr,
  input  logic [pacr_pkg::WAY_W-1:0]         way,
  input  logic                               was_hit,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pacr_pkg::WAY_W-1:0]         victim_way,
  output pacr_pkg::mode_t                    policy_mode,
  input  logic                               cfg_write,
  input  logic [pacr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pacr_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pacr_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_UPD   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]             state;
  logic [SET_W-1:0]       clr_addr;
  logic [SCAN_W-1:0]      scan_k;

  logic [CNT_W-1:0]       threshold;
  logic [CFG_DATA_W-1:0]  neighbor;

  logic                   cur_cmd;
  logic [SET_W-1:0]       cur_set;
  logic [LA_W-1:0]        cur_la;
  logic [WAY_W-1:0]       cur_way;
  logic                   cur_hit;

  // Scan accumulators.
  logic                   hit_any;
  logic [WIN_ROW_W-1:0]   keep_row;
  logic [LA_W-1:0]        sp_best;
  logic [WAY_W-1:0]       sp_vic;
  logic [FREQ_W:0]        lfu_min;
  logic [WAY_W-1:0]       lfu_vic;
  logic [WAY_W-1:0]       nru_vic;
  logic                   nru_found;

  logic [WAY_W-1:0]       res_way;
  mode_t                  res_mode;

  // Memory ports.
  logic                   set_we;
  logic [SET_W-1:0]       set_waddr;
  set_state_t             set_wdata;
  set_state_t             set_rdata;
  logic                   way_we;
  way_row_t               way_wdata;
  way_row_t               way_rdata;
  logic                   win_we;
  logic [SET_W+ROW_AW-1:0] win_waddr;
  logic [SET_W+ROW_AW-1:0] win_raddr;
  logic [WIN_ROW_W-1:0]   win_wdata;
  logic [WIN_ROW_W-1:0]   win_rdata;

  logic                   accept;
  logic                   out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = state != ST_IDLE;
  assign out_free = !out_valid || !out_stall;

  pacr_ram #(.WIDTH($bits(set_state_t)), .DEPTH(NUM_SETS)) u_set_ram (
    .clk, .we(set_we), .waddr(set_waddr), .wdata(set_wdata),
    .raddr(cur_set), .rdata(set_rdata)
  );

  pacr_ram #(.WIDTH($bits(way_row_t)), .DEPTH(NUM_SETS)) u_way_ram (
    .clk, .we(way_we), .waddr(set_waddr), .wdata(way_wdata),
    .raddr(cur_set), .rdata(way_rdata)
  );

  pacr_ram #(.WIDTH(WIN_ROW_W), .DEPTH(NUM_SETS * ROWS)) u_win_ram (
    .clk, .we(win_we), .waddr(win_waddr), .wdata(win_wdata),
    .raddr(win_raddr), .rdata(win_rdata)
  );

  // Window rows are read one ahead of the scan counter.
  assign win_raddr = {cur_set, (state == ST_SCAN) ? ROW_AW'(scan_k + 1'b1) : ROW_AW'(0)};

  // Window hit test for the row now on the read port.
  logic                  row_hit;
  logic [PTR_W-1:0]      ent_idx;
  logic [LA_W-1:0]       ent_la;
  always_comb begin
    row_hit = 1'b0;
    ent_idx = '0;
    ent_la  = '0;
    for (int e = 0; e < ROW_ENTS; e++) begin
      ent_idx = {scan_k, ROW_SEL_W'(e)};
      ent_la  = win_rdata[e*LA_W +: LA_W];
      if ((set_rdata.wrapped || ent_idx < set_rdata.ptr) && ent_la != '0 &&
          la_near(cur_la, ent_la, neighbor)) begin
        row_hit = 1'b1;
      end
    end
  end

  // Per-way victim candidates for the way selected by the scan counter.
  way_entry_t            scan_way;
  logic [LA_W-1:0]       scan_d;
  assign scan_way = way_rdata[scan_k];
  assign scan_d   = la_dist(cur_la, scan_way.tag);

  // Window commit at the end of a query, and phase re-pick when the window pointer wraps.
  set_state_t            fin_ss;
  logic [CNT_W-1:0]      fin_cnt;
  logic [WIN_ROW_W-1:0]  fin_row;
  logic [WAY_W-1:0]      fin_vic;
  always_comb begin
    fin_ss  = set_rdata;
    fin_cnt = set_rdata.scount + CNT_W'(hit_any);
    fin_row = keep_row;
    fin_row[set_rdata.ptr[ROW_SEL_W-1:0]*LA_W +: LA_W] = cur_la;
    fin_ss.ptr    = set_rdata.ptr + 1'b1;
    fin_ss.scount = fin_cnt;
    if (fin_ss.ptr == '0) begin
      fin_ss.wrapped = 1'b1;
      if (fin_cnt >= threshold) begin
        fin_ss.mode = MODE_SPATIAL;
      end else if (set_rdata.hits > set_rdata.misses) begin
        fin_ss.mode = MODE_LFU;
      end else begin
        fin_ss.mode = MODE_NRU;
      end
      fin_ss.scount = '0;
      fin_ss.hits   = '0;
      fin_ss.misses = '0;
    end
    case (fin_ss.mode)
      MODE_SPATIAL: fin_vic = sp_vic;
      MODE_LFU:     fin_vic = lfu_vic;
      default:      fin_vic = nru_found ? nru_vic : '0;
    endcase
  end

  // Replacement state update.
  set_state_t            upd_ss;
  way_row_t              upd_row;
  always_comb begin
    upd_ss  = set_rdata;
    upd_row = way_rdata;
    upd_row[cur_way].tag = cur_la;
    if (cur_hit) begin
      if (upd_ss.hits != '1) begin
        upd_ss.hits = upd_ss.hits + 1'b1;
      end
      if (upd_row[cur_way].freq != FREQ_MAX) begin
        upd_row[cur_way].freq = upd_row[cur_way].freq + 1'b1;
      end
      upd_row[cur_way].stale = 1'b0;
    end else begin
      if (upd_ss.misses != '1) begin
        upd_ss.misses = upd_ss.misses + 1'b1;
      end
      upd_row[cur_way].freq  = FREQ_W'(1);
      upd_row[cur_way].stale = 1'b1;
      if (upd_ss.mode == MODE_SPATIAL) begin
        for (int i = 0; i < NUM_WAYS; i++) begin
          if (la_near(upd_row[i].tag, cur_la, neighbor) && upd_row[i].freq != FREQ_MAX) begin
            upd_row[i].freq = upd_row[i].freq + 1'b1;
          end
        end
      end
    end
  end

  // Memory write selection.
  always_comb begin
    set_we    = 1'b0;
    way_we    = 1'b0;
    win_we    = 1'b0;
    set_waddr = (state == ST_CLEAR) ? clr_addr : cur_set;
    set_wdata = '0;
    way_wdata = upd_row;
    win_waddr = {cur_set, set_rdata.ptr[PTR_W-1:ROW_SEL_W]};
    win_wdata = fin_row;
    case (state)
      ST_CLEAR: begin
        set_we = 1'b1;
        way_we = 1'b1;
        for (int i = 0; i < NUM_WAYS; i++) begin
          way_wdata[i] = '{tag: '0, freq: '0, stale: 1'b1};
        end
      end
      ST_UPD: begin
        set_we    = 1'b1;
        way_we    = 1'b1;
        set_wdata = upd_ss;
      end
      ST_FIN: begin
        set_we    = 1'b1;
        win_we    = 1'b1;
        set_wdata = fin_ss;
      end
      default: begin
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RST;
      neighbor  <= NEIGHBOR_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_THRESHOLD: threshold <= cfg_data[CNT_W-1:0];
        CFG_NEIGHBOR:  neighbor  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input beat capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_cmd <= command;
      cur_set <= set_index;
      cur_la  <= phys_addr[ADDR_W-1:LINE_SHIFT];
      cur_way <= way;
      cur_hit <= was_hit;
    end
  end

  // Scan accumulators: window rows and ways advance together.
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      hit_any   <= 1'b0;
      sp_best   <= '0;
      sp_vic    <= '0;
      lfu_min   <= {1'b1, FREQ_W'(0)};
      lfu_vic   <= '0;
      nru_vic   <= '0;
      nru_found <= 1'b0;
    end else if (state == ST_SCAN) begin
      if (row_hit) begin
        hit_any <= 1'b1;
      end
      if (scan_k == set_rdata.ptr[PTR_W-1:ROW_SEL_W]) begin
        keep_row <= win_rdata;
      end
      if (scan_k == '0 || scan_d > sp_best) begin
        sp_best <= scan_d;
        sp_vic  <= scan_k;
      end
      if ({1'b0, scan_way.freq} < lfu_min) begin
        lfu_min <= {1'b0, scan_way.freq};
        lfu_vic <= scan_k;
      end else if ({1'b0, scan_way.freq} == lfu_min && scan_way.stale) begin
        lfu_vic <= scan_k;
      end
      if (!nru_found && scan_way.stale) begin
        nru_found <= 1'b1;
        nru_vic   <= scan_k;
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      scan_k   <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SET_W'(NUM_SETS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          scan_k <= '0;
          state  <= (cur_cmd == CMD_UPDATE) ? ST_UPD : ST_SCAN;
        end
        ST_SCAN: begin
          scan_k <= scan_k + 1'b1;
          if (scan_k == SCAN_LAST) begin
            state <= ST_FIN;
          end
        end
        ST_FIN:  state <= ST_OUT;
        ST_UPD:  state <= ST_IDLE;
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result held from the commit cycle.
  always_ff @(posedge clk) begin
    if (state == ST_FIN) begin
      res_way  <= fin_vic;
      res_mode <= fin_ss.mode;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      victim_way  <= res_way;
      policy_mode <= res_mode;
    end
  end

endmodule

### sv/pacr_ram.sv
module pacr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/pacr_checker.sv
`include "assert_macros.svh"

module pacr_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input pacr_pkg::mode_t policy_mode
);
  import pacr_pkg::*;

  // A stalled output beat stays offered.
  `PACR_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid, "output beat dropped")

  // The block works on one item at a time.
  `PACR_ASSERT(a_one_item, clk, rst, in_valid && !in_stall |=> in_stall, "second item taken")

  // Only the three defined modes are reported.
  `PACR_ASSERT(a_mode_ok, clk, rst, out_valid |-> policy_mode <= MODE_SPATIAL, "bad mode")

  // The clearing pass holds off input right after reset.
  `PACR_ASSERT_ALWAYS(a_clear_stall, clk, rst |=> in_stall, "input open during clear")

endmodule

bind phase_adaptive_cache_replacement_core pacr_checker u_pacr_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .policy_mode(policy_mode)
);
